@@ hw/rtl/dbq_pkg.sv @@
// dbq_pkg: shared types and constants for the doorbell button qualifier
// used by dbq_debounce and doorbell_button_qualifier; no dependencies
package dbq_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 2;

    // released button reads high
    localparam logic LEVEL_HIGH = 1'b1;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd50;
    localparam logic [COUNT_W-1:0] LIMIT_RST    = 8'd3;
    localparam logic [TIME_W-1:0]  WINDOW_RST   = 32'd10000;
    localparam logic [TIME_W-1:0]  HOLD_RST     = 32'd2000;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LIMIT    = 2'd1,
        CFG_WINDOW   = 2'd2,
        CFG_HOLD     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              press;
        logic              release_ev;
        logic              level;
        logic [TIME_W-1:0] extra;
    } dbq_btn_t;

endpackage

@@ hw/rtl/dbq_debounce.sv @@
// dbq_debounce: timestamp debouncer for one button with raw edge counting
// depends on dbq_pkg
module dbq_debounce (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       raw,
    input  logic [dbq_pkg::TIME_W-1:0] now_ms,
    input  logic [dbq_pkg::DEB_W-1:0]  settle_ms,
    output dbq_pkg::dbq_btn_t          status
);
    import dbq_pkg::*;

    logic              stable_reg, stable_next;
    logic              last_raw_reg;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic [TIME_W-1:0] total_reg, total_next;
    logic [TIME_W-1:0] at_accept_reg, at_accept_next;
    logic              changed;
    logic              accept;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] pending;

    always_comb
    begin
        changed          = (raw != last_raw_reg);
        change_time_next = changed ? now_ms : change_time_reg;
        total_next       = total_reg + {{(TIME_W-1){1'b0}}, changed};
        since            = now_ms - change_time_next;
        accept           = (raw != stable_reg)
                        && (since >= {{(TIME_W-DEB_W){1'b0}}, settle_ms});
        stable_next      = accept ? raw : stable_reg;
        at_accept_next   = accept ? total_next : at_accept_reg;
        pending          = total_next - at_accept_next;

        status.press      = accept && (raw != LEVEL_HIGH);
        status.release_ev = accept && (raw == LEVEL_HIGH);
        status.level      = stable_next;
        status.extra      = (pending > {{(TIME_W-1){1'b0}}, 1'b1})
                          ? pending - {{(TIME_W-1){1'b0}}, 1'b1} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= LEVEL_HIGH;
            last_raw_reg    <= LEVEL_HIGH;
            change_time_reg <= '0;
            total_reg       <= '0;
            at_accept_reg   <= '0;
        end
        else if (advance)
        begin
            stable_reg      <= stable_next;
            last_raw_reg    <= raw;
            change_time_reg <= change_time_next;
            total_reg       <= total_next;
            at_accept_reg   <= at_accept_next;
        end
    end

endmodule

@@ hw/rtl/doorbell_button_qualifier.sv @@
// doorbell_button_qualifier: top level, bell press counter and talk button logic
// depends on dbq_pkg and dbq_debounce
//
// Usage: each input transfer is one poll (now_ms, bell_level, talk_level) on the
// in_valid / in_stall channel; every poll yields exactly one result transfer on
// the out_valid / out_stall channel. Buttons are active low (1 = released).
// On its way from input transfer to out_valid, the poll lands in an
// input register, then the debounce, window and hold logic runs in one pass
// into the result register, updating the button state in the same edge.
// One poll per cycle while the receiver does not stall, set by that single registered pass.
// When the receiver stalls, the result register holds and one more poll may
// wait in the input register; in_stall rises only when both are full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge; the user must make them only while the block is idle (not enforced here).
// Reset (rst_n low, asynchronous) empties both registers, restores the default
// settings and returns both buttons to released with all counters cleared.
module doorbell_button_qualifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dbq_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dbq_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dbq_pkg::TIME_W-1:0]  now_ms,
    input  logic                        bell_level,
    input  logic                        talk_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        window_expired,
    output logic                        bell_press,
    output logic [dbq_pkg::COUNT_W-1:0] press_count,
    output logic                        lock_out,
    output logic [dbq_pkg::TIME_W-1:0]  bell_bounce,
    output logic                        talk_press,
    output logic [dbq_pkg::TIME_W-1:0]  talk_bounce,
    output logic                        talk_release,
    output logic                        release_after_talk,
    output logic [dbq_pkg::TIME_W-1:0]  held_time_ms,
    output logic                        talk_start
);
    import dbq_pkg::*;

    logic [DEB_W-1:0]   debounce_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic [TIME_W-1:0]  window_reg;
    logic [TIME_W-1:0]  hold_reg;

    logic              in_full_reg;
    logic [TIME_W-1:0] now_reg;
    logic              bell_raw_reg;
    logic              talk_raw_reg;
    logic              out_full_reg;
    logic              advance;
    logic              take_in;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               locked_reg, locked_next;
    logic [TIME_W-1:0]  last_bell_reg, last_bell_next;
    logic [TIME_W-1:0]  pressed_time_reg, pressed_time_next;
    logic               fired_reg, fired_next;

    logic [COUNT_W-1:0] count_mid;
    logic               locked_mid;
    logic               fired_mid;
    logic               expired;
    logic               after_talk;
    logic [TIME_W-1:0]  held;
    logic               tstart;

    dbq_btn_t bell_st;
    dbq_btn_t talk_st;

    // input register moves on when the result register is free or draining
    assign advance   = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign take_in   = in_valid && !in_stall;
    assign out_valid = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            limit_reg    <= LIMIT_RST;
            window_reg   <= WINDOW_RST;
            hold_reg     <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_data[COUNT_W-1:0];
                CFG_WINDOW:   window_reg   <= cfg_data[TIME_W-1:0];
                CFG_HOLD:     hold_reg     <= cfg_data[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_full_reg <= 1'b1;
            else if (!out_stall)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            now_reg      <= now_ms;
            bell_raw_reg <= bell_level;
            talk_raw_reg <= talk_level;
        end
    end

    dbq_debounce u_bell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw       (bell_raw_reg),
        .now_ms    (now_reg),
        .settle_ms (debounce_reg),
        .status    (bell_st)
    );

    dbq_debounce u_talk (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw       (talk_raw_reg),
        .now_ms    (now_reg),
        .settle_ms (debounce_reg),
        .status    (talk_st)
    );

    always_comb
    begin
        // quiet window
        expired    = (count_reg != '0) && ((now_reg - last_bell_reg) >= window_reg);
        count_mid  = expired ? '0 : count_reg;
        locked_mid = expired ? 1'b0 : locked_reg;

        // bell press counter
        count_next     = count_mid;
        locked_next    = locked_mid;
        last_bell_next = last_bell_reg;
        if (bell_st.press)
        begin
            last_bell_next = now_reg;
            if (count_mid < limit_reg)
                count_next = count_mid + {{(COUNT_W-1){1'b0}}, 1'b1};
            locked_next = (count_next >= limit_reg);
        end

        // talk press and release
        pressed_time_next = pressed_time_reg;
        fired_mid         = fired_reg;
        after_talk        = 1'b0;
        held              = '0;
        if (talk_st.press)
        begin
            pressed_time_next = now_reg;
            fired_mid         = 1'b0;
        end
        else if (talk_st.release_ev)
        begin
            if (fired_reg)
                after_talk = 1'b1;
            else
                held = now_reg - pressed_time_reg;
        end

        // hold threshold
        tstart     = (talk_st.level != LEVEL_HIGH) && !fired_mid
                  && ((now_reg - pressed_time_next) >= hold_reg);
        fired_next = fired_mid || tstart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            locked_reg       <= 1'b0;
            last_bell_reg    <= '0;
            pressed_time_reg <= '0;
            fired_reg        <= 1'b0;
        end
        else if (advance)
        begin
            count_reg        <= count_next;
            locked_reg       <= locked_next;
            last_bell_reg    <= last_bell_next;
            pressed_time_reg <= pressed_time_next;
            fired_reg        <= fired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_expired     <= expired;
            bell_press         <= bell_st.press;
            press_count        <= count_next;
            lock_out           <= locked_next;
            bell_bounce        <= bell_st.extra;
            talk_press         <= talk_st.press;
            talk_bounce        <= talk_st.extra;
            talk_release       <= talk_st.release_ev;
            release_after_talk <= after_talk;
            held_time_ms       <= held;
            talk_start         <= tstart;
        end
    end

endmodule
